// ===== hdl/pareto_archive_2d_insert_top_assert.svh =====
// assertion macros for the pareto archive block
`ifndef PARETO_ARCHIVE_2D_INSERT_TOP_ASSERT_SVH
`define PARETO_ARCHIVE_2D_INSERT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PA2D_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pareto archive assertion failed");
`define PA2D_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("pareto archive reset assertion failed");
`else
`define PA2D_ASSERT(lbl, prop)
`define PA2D_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== hdl/pa2d_pkg.sv =====
`timescale 1ns / 1ps
package pa2d_pkg;
    localparam int CAPACITY_DEF = 256;
    localparam int OBJ_W_DEF    = 32;
    localparam int ID_W_DEF     = 20;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_INFEAS = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [2:0] ST_INSERTED   = 3'd0;
    localparam logic [2:0] ST_DOMINATED  = 3'd1;
    localparam logic [2:0] ST_INFEASIBLE = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_READ_OK    = 3'd4;
    localparam logic [2:0] ST_READ_EMPTY = 3'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] read_slot;
    } t_ctl;
endpackage

// ===== hdl/pareto_archive_2d_insert_top.sv =====
`timescale 1ns / 1ps
// two-objective pareto archive, minimization, entries sorted by first objective
// input channel (i_valid/o_ready): operation 0 offers a feasible candidate for
// insertion (an infeasible one is only reported), 1 reads the entry at
// i_read_slot. output channel (o_valid/i_ready): one result item per input
// item, in order, with status, occupancy, removed count and slot. a two-deep
// queue sits between the classifying front and the archive engine, and a result
// register sits at the output, so the next item is taken while a result waits.
// a read past occupancy or an infeasible item goes straight to the result; a
// read within occupancy fetches its entry first. an insert runs a binary search
// on the first objective, checks the neighbors, scans the dominated entries and
// moves entries in the archive memory to open or close the gap; one item is in
// the engine at a time.
// reset empties the archive (occupancy zero); memory contents need no clear.
// when the receiver stalls the result register holds, the engine waits at
// its result, and the queue then fills and drops o_ready.
module pareto_archive_2d_insert_top #(
    parameter int CAPACITY        = pa2d_pkg::CAPACITY_DEF,
    parameter int OBJECTIVE_WIDTH = pa2d_pkg::OBJ_W_DEF,
    parameter int ID_WIDTH        = pa2d_pkg::ID_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_operation,
    input  logic signed [OBJECTIVE_WIDTH-1:0] i_first_objective,
    input  logic signed [OBJECTIVE_WIDTH-1:0] i_second_objective,
    input  logic                              i_feasible,
    input  logic [ID_WIDTH-1:0]               i_candidate_id,
    input  logic [7:0]                        i_read_slot,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_status,
    output logic [8:0]                        o_entry_total,
    output logic [8:0]                        o_removed_total,
    output logic [7:0]                        o_slot_used,
    output logic signed [OBJECTIVE_WIDTH-1:0] o_entry_first,
    output logic signed [OBJECTIVE_WIDTH-1:0] o_entry_second,
    output logic [ID_WIDTH-1:0]               o_entry_id
);
`include "pareto_archive_2d_insert_top_assert.svh"

    logic                              w_q_valid, w_q_ready;
    logic signed [OBJECTIVE_WIDTH-1:0] w_q_first, w_q_second;
    logic [ID_WIDTH-1:0]               w_q_id;
    pa2d_pkg::t_ctl                    w_q_ctl;

    pa2d_front #(
        .OBJECTIVE_WIDTH(OBJECTIVE_WIDTH),
        .ID_WIDTH       (ID_WIDTH)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_operation       (i_operation),
        .i_first_objective (i_first_objective),
        .i_second_objective(i_second_objective),
        .i_feasible        (i_feasible),
        .i_candidate_id    (i_candidate_id),
        .i_read_slot       (i_read_slot),
        .o_q_valid         (w_q_valid),
        .i_q_ready         (w_q_ready),
        .o_q_first         (w_q_first),
        .o_q_second        (w_q_second),
        .o_q_id            (w_q_id),
        .o_q_ctl           (w_q_ctl)
    );

    pa2d_back #(
        .CAPACITY       (CAPACITY),
        .OBJECTIVE_WIDTH(OBJECTIVE_WIDTH),
        .ID_WIDTH       (ID_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .o_q_ready      (w_q_ready),
        .i_q_first      (w_q_first),
        .i_q_second     (w_q_second),
        .i_q_id         (w_q_id),
        .i_q_ctl        (w_q_ctl),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_entry_total  (o_entry_total),
        .o_removed_total(o_removed_total),
        .o_slot_used    (o_slot_used),
        .o_entry_first  (o_entry_first),
        .o_entry_second (o_entry_second),
        .o_entry_id     (o_entry_id)
    );

    `PA2D_ASSERT(a_only_insert_removes, o_valid && o_status != pa2d_pkg::ST_INSERTED |-> o_removed_total == 9'd0)
    `PA2D_ASSERT(a_empty_read_zero, o_valid && o_status == pa2d_pkg::ST_READ_EMPTY |-> o_entry_first == '0 && o_entry_second == '0 && o_entry_id == '0)
    `PA2D_ASSERT(a_infeas_slot_zero, o_valid && o_status == pa2d_pkg::ST_INFEASIBLE |-> o_slot_used == 8'd0)
    `PA2D_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_valid && o_ready)
endmodule

// ===== hdl/pa2d_front.sv =====
`timescale 1ns / 1ps
module pa2d_front #(
    parameter int OBJECTIVE_WIDTH = pa2d_pkg::OBJ_W_DEF,
    parameter int ID_WIDTH        = pa2d_pkg::ID_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_operation,
    input  logic signed [OBJECTIVE_WIDTH-1:0] i_first_objective,
    input  logic signed [OBJECTIVE_WIDTH-1:0] i_second_objective,
    input  logic                              i_feasible,
    input  logic [ID_WIDTH-1:0]               i_candidate_id,
    input  logic [7:0]                        i_read_slot,
    output logic                              o_q_valid,
    input  logic                              i_q_ready,
    output logic signed [OBJECTIVE_WIDTH-1:0] o_q_first,
    output logic signed [OBJECTIVE_WIDTH-1:0] o_q_second,
    output logic [ID_WIDTH-1:0]               o_q_id,
    output pa2d_pkg::t_ctl                    o_q_ctl
);
    logic signed [OBJECTIVE_WIDTH-1:0] r_first  [2];
    logic signed [OBJECTIVE_WIDTH-1:0] r_second [2];
    logic [ID_WIDTH-1:0]               r_id     [2];
    pa2d_pkg::t_ctl                    r_ctl    [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    pa2d_pkg::t_ctl w_ctl;

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_q_valid && i_q_ready;

    always_comb begin
        w_ctl.read_slot = i_read_slot;
        if (i_operation) begin
            w_ctl.kind = pa2d_pkg::KIND_READ;
        end else if (!i_feasible) begin
            w_ctl.kind = pa2d_pkg::KIND_INFEAS;
        end else begin
            w_ctl.kind = pa2d_pkg::KIND_INSERT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_first[r_wp]  <= i_first_objective;
            r_second[r_wp] <= i_second_objective;
            r_id[r_wp]     <= i_candidate_id;
            r_ctl[r_wp]    <= w_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_first  = r_first[r_rp];
    assign o_q_second = r_second[r_rp];
    assign o_q_id     = r_id[r_rp];
    assign o_q_ctl    = r_ctl[r_rp];
endmodule

// ===== hdl/pa2d_back.sv =====
`timescale 1ns / 1ps
module pa2d_back #(
    parameter int CAPACITY        = pa2d_pkg::CAPACITY_DEF,
    parameter int OBJECTIVE_WIDTH = pa2d_pkg::OBJ_W_DEF,
    parameter int ID_WIDTH        = pa2d_pkg::ID_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    output logic                              o_q_ready,
    input  logic signed [OBJECTIVE_WIDTH-1:0] i_q_first,
    input  logic signed [OBJECTIVE_WIDTH-1:0] i_q_second,
    input  logic [ID_WIDTH-1:0]               i_q_id,
    input  pa2d_pkg::t_ctl                    i_q_ctl,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_status,
    output logic [8:0]                        o_entry_total,
    output logic [8:0]                        o_removed_total,
    output logic [7:0]                        o_slot_used,
    output logic signed [OBJECTIVE_WIDTH-1:0] o_entry_first,
    output logic signed [OBJECTIVE_WIDTH-1:0] o_entry_second,
    output logic [ID_WIDTH-1:0]               o_entry_id
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OW = $clog2(CAPACITY + 1);
    localparam int CW = (OW > 9) ? OW : 9;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_BS       = 4'd1;
    localparam logic [3:0] S_BS_CMP   = 4'd2;
    localparam logic [3:0] S_PREV_CMP = 4'd3;
    localparam logic [3:0] S_AT       = 4'd4;
    localparam logic [3:0] S_AT_CMP   = 4'd5;
    localparam logic [3:0] S_SCAN     = 4'd6;
    localparam logic [3:0] S_SCAN_CMP = 4'd7;
    localparam logic [3:0] S_DECIDE   = 4'd8;
    localparam logic [3:0] S_COPY_RD  = 4'd9;
    localparam logic [3:0] S_COPY_WR  = 4'd10;
    localparam logic [3:0] S_PLACE    = 4'd11;
    localparam logic [3:0] S_RD_WAIT  = 4'd12;
    localparam logic [3:0] S_EMIT     = 4'd13;

    logic signed [OBJECTIVE_WIDTH-1:0] mem_first  [CAPACITY];
    logic signed [OBJECTIVE_WIDTH-1:0] mem_second [CAPACITY];
    logic [ID_WIDTH-1:0]               mem_id     [CAPACITY];
    logic signed [OBJECTIVE_WIDTH-1:0] r_rd_first, r_rd_second;
    logic [ID_WIDTH-1:0]               r_rd_id;

    logic [3:0]    r_state, n_state;
    logic [OW-1:0] r_occ, n_occ, r_lo, n_lo, r_hi, n_hi, r_end, n_end;
    logic [OW-1:0] r_src, n_src, r_rmv, n_rmv;
    logic          r_desc, n_desc;
    logic signed [OBJECTIVE_WIDTH-1:0] r_x0, n_x0, r_x1, n_x1;
    logic [ID_WIDTH-1:0] r_xid, n_xid;
    logic [7:0]    r_slot, n_slot;
    logic [2:0]    r_st, n_st;
    logic [OW:0]   w_sum;
    logic [OW-1:0] w_mid;
    logic [CW-1:0] w_slot_ext, w_occ_ext, w_pos_ext, w_rmv_ext;

    logic [OW-1:0] w_ra, w_wa;
    logic          w_we, w_wcand;

    logic          r_o_valid;
    logic          w_load;

    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[OW:1];
    assign w_occ_ext  = CW'(r_occ);
    assign w_pos_ext  = CW'(r_lo);
    assign w_rmv_ext  = CW'(r_rmv);
    assign w_slot_ext = CW'(i_q_ctl.read_slot);
    assign o_q_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_end   = r_end;
        n_src   = r_src;
        n_rmv   = r_rmv;
        n_desc  = r_desc;
        n_x0    = r_x0;
        n_x1    = r_x1;
        n_xid   = r_xid;
        n_slot  = r_slot;
        n_st    = r_st;
        w_ra    = '0;
        w_wa    = '0;
        w_we    = 1'b0;
        w_wcand = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_x0  = i_q_first;
                    n_x1  = i_q_second;
                    n_xid = i_q_id;
                    n_rmv = '0;
                    n_lo  = '0;
                    n_hi  = r_occ;
                    n_slot = 8'd0;
                    case (i_q_ctl.kind)
                        pa2d_pkg::KIND_READ: begin
                            n_slot = i_q_ctl.read_slot;
                            w_ra   = OW'(w_slot_ext);
                            if (w_slot_ext < w_occ_ext) begin
                                n_state = S_RD_WAIT;
                            end else begin
                                n_st    = pa2d_pkg::ST_READ_EMPTY;
                                n_state = S_EMIT;
                            end
                        end
                        pa2d_pkg::KIND_INFEAS: begin
                            n_st    = pa2d_pkg::ST_INFEASIBLE;
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_BS;
                        end
                    endcase
                end
            end
            S_BS: begin
                if (r_lo < r_hi) begin
                    w_ra    = w_mid;
                    n_state = S_BS_CMP;
                end else begin
                    n_slot = w_pos_ext[7:0];
                    if (r_lo != '0) begin
                        w_ra    = r_lo - 1'b1;
                        n_state = S_PREV_CMP;
                    end else begin
                        n_state = S_AT;
                    end
                end
            end
            S_BS_CMP: begin
                if (r_rd_first < r_x0) begin
                    n_lo = w_mid + 1'b1;
                end else begin
                    n_hi = w_mid;
                end
                n_state = S_BS;
            end
            S_PREV_CMP: begin
                if (r_rd_second <= r_x1) begin
                    n_st    = pa2d_pkg::ST_DOMINATED;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_AT;
                end
            end
            S_AT: begin
                n_end = r_lo;
                if (r_lo < r_occ) begin
                    w_ra    = r_lo;
                    n_state = S_AT_CMP;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_AT_CMP: begin
                if (r_rd_first == r_x0 && r_rd_second <= r_x1) begin
                    n_st    = pa2d_pkg::ST_DOMINATED;
                    n_state = S_EMIT;
                end else if (!(r_rd_second < r_x1)) begin
                    n_end   = r_lo + 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_SCAN: begin
                if (r_end < r_occ) begin
                    w_ra    = r_end;
                    n_state = S_SCAN_CMP;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_SCAN_CMP: begin
                if (!(r_rd_second < r_x1)) begin
                    n_end   = r_end + 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_rmv = r_end - r_lo;
                if (r_end == r_lo && w_occ_ext >= CW'(CAPACITY)) begin
                    n_st    = pa2d_pkg::ST_FULL;
                    n_state = S_EMIT;
                end else if (r_end == r_lo) begin
                    n_desc  = 1'b1;
                    n_src   = r_occ;
                    n_state = S_COPY_RD;
                end else begin
                    n_desc  = 1'b0;
                    n_src   = r_end;
                    n_state = S_COPY_RD;
                end
            end
            S_COPY_RD: begin
                if (r_desc) begin
                    if (r_src == r_lo) begin
                        n_state = S_PLACE;
                    end else begin
                        w_ra    = r_src - 1'b1;
                        n_state = S_COPY_WR;
                    end
                end else begin
                    if (r_src == r_occ) begin
                        n_state = S_PLACE;
                    end else begin
                        w_ra    = r_src;
                        n_state = S_COPY_WR;
                    end
                end
            end
            S_COPY_WR: begin
                w_we = 1'b1;
                if (r_desc) begin
                    w_wa  = r_src;
                    n_src = r_src - 1'b1;
                end else begin
                    w_wa  = r_src - r_rmv + 1'b1;
                    n_src = r_src + 1'b1;
                end
                n_state = S_COPY_RD;
            end
            S_PLACE: begin
                w_we    = 1'b1;
                w_wcand = 1'b1;
                w_wa    = r_lo;
                n_occ   = r_occ - r_rmv + 1'b1;
                n_st    = pa2d_pkg::ST_INSERTED;
                n_state = S_EMIT;
            end
            S_RD_WAIT: begin
                w_ra    = OW'(r_slot);
                n_st    = pa2d_pkg::ST_READ_OK;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                w_ra = OW'(r_slot);
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_first[w_wa[AW-1:0]]  <= w_wcand ? r_x0  : r_rd_first;
            mem_second[w_wa[AW-1:0]] <= w_wcand ? r_x1  : r_rd_second;
            mem_id[w_wa[AW-1:0]]     <= w_wcand ? r_xid : r_rd_id;
        end
        r_rd_first  <= mem_first[w_ra[AW-1:0]];
        r_rd_second <= mem_second[w_ra[AW-1:0]];
        r_rd_id     <= mem_id[w_ra[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_end  <= n_end;
        r_src  <= n_src;
        r_rmv  <= n_rmv;
        r_desc <= n_desc;
        r_x0   <= n_x0;
        r_x1   <= n_x1;
        r_xid  <= n_xid;
        r_slot <= n_slot;
        r_st   <= n_st;
    end

    // output register
    assign w_load = (r_state == S_EMIT) && (!r_o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_status        <= r_st;
            o_entry_total   <= w_occ_ext[8:0];
            o_removed_total <= (r_st == pa2d_pkg::ST_INSERTED) ? w_rmv_ext[8:0] : 9'd0;
            o_slot_used     <= r_slot;
            if (r_st == pa2d_pkg::ST_READ_OK) begin
                o_entry_first  <= r_rd_first;
                o_entry_second <= r_rd_second;
                o_entry_id     <= r_rd_id;
            end else begin
                o_entry_first  <= '0;
                o_entry_second <= '0;
                o_entry_id     <= '0;
            end
        end
    end

    assign o_valid = r_o_valid;
endmodule
